// File: rtl/core/wfg_pkg.sv
// Shared types and constants for the wait-for graph deadlock detector.
`timescale 1ns / 1ps

package wfg_pkg;

    localparam int DEF_MAX_TXNS  = 16;
    localparam int DEF_TIME_BITS = 32;
    localparam int KIND_W        = 2;
    localparam int TXN_W         = 4;
    localparam int IN_TIME_W     = 32;
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 2'd0,
        KIND_EDGE   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CLOSE,
        ST_FIND,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic set_edge;
        logic remove;
    } t_row_ctl;

    typedef struct packed {
        logic step;
        logic pick;
    } t_clo_ctl;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clear;
    } t_scan_ctl;

endpackage

// File: rtl/core/wfg_wait_mem.sv
// Wait-for matrix memory with read-modify-write row sweep.
`timescale 1ns / 1ps

module wfg_wait_mem #(
    parameter int MAX_TXNS = 16,
    parameter int SW       = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wfg_pkg::t_row_ctl    i_ctl,
    input  logic [SW-1:0]        i_rd_addr,
    input  logic [SW-1:0]        i_a,
    input  logic [SW-1:0]        i_b,
    output logic                 o_row_valid,
    output logic [SW-1:0]        o_row_idx,
    output logic [MAX_TXNS-1:0]  o_row
);
    import wfg_pkg::*;

    logic [MAX_TXNS-1:0] r_mem [MAX_TXNS];
    logic [MAX_TXNS-1:0] r_valid;
    logic [MAX_TXNS-1:0] r_rd_data;
    logic                r_rd_ok;
    logic                r_wb_en;
    logic [SW-1:0]       r_wb_addr;
    logic [MAX_TXNS-1:0] n_row;

    always_comb begin
        n_row = r_rd_ok ? r_rd_data : '0;
        if (i_ctl.remove) begin
            n_row[i_a] = 1'b0;
            if (r_wb_addr == i_a) begin
                n_row = '0;
            end
        end
        if (i_ctl.set_edge && r_wb_addr == i_a) begin
            n_row[i_b] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (r_wb_en) begin
            r_mem[r_wb_addr] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_wb_en   <= 1'b0;
            r_rd_ok   <= 1'b0;
            r_wb_addr <= '0;
        end else begin
            r_wb_en <= i_ctl.rd_en;
            if (i_ctl.rd_en) begin
                r_wb_addr <= i_rd_addr;
                r_rd_ok   <= r_valid[i_rd_addr];
            end
            if (r_wb_en) begin
                r_valid[r_wb_addr] <= 1'b1;
            end
        end
    end

    assign o_row_valid = r_wb_en;
    assign o_row_idx   = r_wb_addr;
    assign o_row       = n_row;

endmodule

// File: rtl/core/wfg_closure.sv
// Reachability rows, one closure pivot per cycle, and cycle component pick.
`timescale 1ns / 1ps

module wfg_closure #(
    parameter int MAX_TXNS = 16,
    parameter int SW       = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wfg_pkg::t_clo_ctl    i_ctl,
    input  logic                 i_load,
    input  logic [SW-1:0]        i_load_idx,
    input  logic [MAX_TXNS-1:0]  i_load_row,
    input  logic [SW-1:0]        i_k,
    output logic                 o_found,
    output logic [MAX_TXNS-1:0]  o_member
);
    import wfg_pkg::*;

    logic [MAX_TXNS-1:0] r_reach [MAX_TXNS];
    logic                r_found;
    logic [MAX_TXNS-1:0] r_member;
    logic                n_found;
    logic [SW-1:0]       n_first;
    logic [MAX_TXNS-1:0] n_member;

    always_comb begin
        n_found = 1'b0;
        n_first = '0;
        for (int i = MAX_TXNS - 1; i >= 0; i--) begin
            if (r_reach[i][i]) begin
                n_found = 1'b1;
                n_first = SW'(i);
            end
        end
        for (int i = 0; i < MAX_TXNS; i++) begin
            n_member[i] = (n_first == SW'(i)) ||
                          (r_reach[n_first][i] && r_reach[i][n_first]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_reach[i_load_idx] <= i_load_row;
        end else if (i_ctl.step) begin
            for (int i = 0; i < MAX_TXNS; i++) begin
                if (r_reach[i][i_k]) begin
                    r_reach[i] <= r_reach[i] | r_reach[i_k];
                end
            end
        end
        if (i_ctl.pick) begin
            r_member <= n_member;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.pick) begin
            r_found <= n_found;
        end
    end

    assign o_found  = r_found;
    assign o_member = r_member;

endmodule

// File: rtl/core/wfg_time_scan.sv
// Start time memory and youngest-member scan.
`timescale 1ns / 1ps

module wfg_time_scan #(
    parameter int MAX_TXNS = 16,
    parameter int SW       = 4,
    parameter int TW       = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wfg_pkg::t_scan_ctl   i_ctl,
    input  logic [SW-1:0]        i_addr,
    input  logic [TW-1:0]        i_wr_data,
    input  logic [MAX_TXNS-1:0]  i_member,
    output logic [SW-1:0]        o_victim
);
    import wfg_pkg::*;

    logic [TW-1:0]       r_mem [MAX_TXNS];
    logic [MAX_TXNS-1:0] r_valid;
    logic [TW-1:0]       r_rd_data;
    logic                r_rd_ok;
    logic                r_cmp_en;
    logic [SW-1:0]       r_cmp_idx;
    logic                r_have;
    logic [TW-1:0]       r_best;
    logic [SW-1:0]       r_victim;
    logic [TW-1:0]       n_time;
    logic                n_take;

    assign n_time = r_rd_ok ? r_rd_data : '0;
    assign n_take = r_cmp_en && i_member[r_cmp_idx] && (!r_have || n_time > r_best);

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
        if (n_take) begin
            r_best   <= n_time;
            r_victim <= r_cmp_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_ok   <= 1'b0;
            r_cmp_en  <= 1'b0;
            r_cmp_idx <= '0;
            r_have    <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_addr] <= 1'b1;
            end
            r_cmp_en <= i_ctl.rd_en;
            if (i_ctl.rd_en) begin
                r_rd_ok   <= r_valid[i_addr];
                r_cmp_idx <= i_addr;
            end
            if (i_ctl.clear) begin
                r_have <= 1'b0;
            end else if (n_take) begin
                r_have <= 1'b1;
            end
        end
    end

    assign o_victim = r_victim;

endmodule

// File: rtl/core/wait_for_graph_deadlock_detector.sv
// Row sweep of the wait matrix memory, one closure pivot per cycle, component pick,
// start time memory scan, output.
// One item is processed at a time: input is accepted only in idle, but the next item is
// taken while a result waits.
// Reset: synchronous active low; graph and start times read as zero after reset.
`timescale 1ns / 1ps

module wait_for_graph_deadlock_detector #(
    parameter int MAX_TXNS  = wfg_pkg::DEF_MAX_TXNS,
    parameter int TIME_BITS = wfg_pkg::DEF_TIME_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // first_txn[3:0], second_txn[7:4], start_time[39:8]
    input  logic [wfg_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind[1:0]
    input  logic [wfg_pkg::KIND_W-1:0]     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // deadlock[0], victim_txn[4:1], zero[7:5]
    output logic [wfg_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import wfg_pkg::*;

    localparam int SW = (MAX_TXNS > 1) ? $clog2(MAX_TXNS) : 1;
    localparam int CW = $clog2(MAX_TXNS + 1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    t_kind               r_kind;
    logic [TXN_W-1:0]    r_a, r_b;
    logic [TIME_BITS-1:0] r_time;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                s_accept;
    logic                a_ok, b_ok;
    logic                load_out;
    t_row_ctl            row_ctl;
    t_clo_ctl            clo_ctl;
    t_scan_ctl           scan_ctl;
    logic                row_valid;
    logic [SW-1:0]       row_idx;
    logic [MAX_TXNS-1:0] row_data;
    logic                found;
    logic [MAX_TXNS-1:0] member;
    logic [SW-1:0]       victim;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign a_ok     = int'(r_a) < MAX_TXNS;
    assign b_ok     = int'(r_b) < MAX_TXNS;

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        o_s_axis_tready = 1'b0;
        load_out        = 1'b0;
        row_ctl         = '0;
        clo_ctl         = '0;
        scan_ctl        = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                n_cnt           = '0;
                if (i_s_axis_tvalid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                row_ctl.set_edge = (r_kind == KIND_EDGE) && a_ok && b_ok && (r_a != r_b);
                row_ctl.remove   = (r_kind == KIND_REMOVE) && a_ok;
                scan_ctl.wr_en   = (r_cnt == '0) && (r_kind == KIND_START) && a_ok;
                if (r_cnt == CW'(MAX_TXNS)) begin
                    n_cnt   = '0;
                    n_state = ST_CLOSE;
                end else begin
                    row_ctl.rd_en = 1'b1;
                    n_cnt         = r_cnt + 1'b1;
                end
            end
            ST_CLOSE: begin
                clo_ctl.step = 1'b1;
                if (r_cnt == CW'(MAX_TXNS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_FIND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FIND: begin
                clo_ctl.pick   = 1'b1;
                scan_ctl.clear = 1'b1;
                n_state        = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_cnt == CW'(MAX_TXNS)) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end else begin
                    scan_ctl.rd_en = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kind <= t_kind'(i_s_axis_tuser);
            r_a    <= i_s_axis_tdata[TXN_W-1:0];
            r_b    <= i_s_axis_tdata[2*TXN_W-1:TXN_W];
            r_time <= TIME_BITS'(i_s_axis_tdata[2*TXN_W +: IN_TIME_W]);
        end
        if (load_out) begin
            r_out_data <= found ? {3'b000, TXN_W'(victim), 1'b1} : '0;
        end
    end

    wfg_wait_mem #(
        .MAX_TXNS (MAX_TXNS),
        .SW       (SW)
    ) u_wait_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (row_ctl),
        .i_rd_addr   (r_cnt[SW-1:0]),
        .i_a         (SW'(r_a)),
        .i_b         (SW'(r_b)),
        .o_row_valid (row_valid),
        .o_row_idx   (row_idx),
        .o_row       (row_data)
    );

    wfg_closure #(
        .MAX_TXNS (MAX_TXNS),
        .SW       (SW)
    ) u_closure (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (clo_ctl),
        .i_load     (row_valid),
        .i_load_idx (row_idx),
        .i_load_row (row_data),
        .i_k        (r_cnt[SW-1:0]),
        .o_found    (found),
        .o_member   (member)
    );

    wfg_time_scan #(
        .MAX_TXNS (MAX_TXNS),
        .SW       (SW),
        .TW       (TIME_BITS)
    ) u_time_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_addr    (scan_ctl.wr_en ? SW'(r_a) : r_cnt[SW-1:0]),
        .i_wr_data (r_time),
        .i_member  (member),
        .o_victim  (victim)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("input taken while busy");

    a_no_victim_without_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[4:1] == '0))
        else $error("victim reported without deadlock");

    a_close_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLOSE) |-> (r_cnt < CW'(MAX_TXNS)))
        else $error("closure pivot out of range");

    a_load_row_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_valid |-> ($past(r_state) == ST_LOAD))
        else $error("row writeback outside sweep");
`endif

endmodule
